// ----- design/sha1_stream_hash_unit_macros.svh -----
// Assertion macros shared by the SHA-1 stream hash RTL
`ifndef SHA1_STREAM_HASH_UNIT_MACROS_SVH
`define SHA1_STREAM_HASH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SHA1SH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1 stream hash: assertion failed");

// Next-cycle implication, checked outside reset
`define SHA1SH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 stream hash: assertion failed");

`endif

// ----- design/sha1sh_pkg.sv -----
// Types and constants of the SHA-1 stream hash unit
`timescale 1ns / 1ps
`default_nettype none

package sha1sh_pkg;

  // Five working / chaining words
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  // Control from the sequencer to the message schedule
  typedef struct packed {
    logic       load_byte;
    logic       shift_word;
    logic [7:0] byte_val;
  } sched_ctrl_t;

  localparam work_t H_INIT = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam logic [31:0] K_TAB [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [6:0] ROUND_COUNT = 7'd80;
  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [6:0] ROUND_B1    = 7'd20;
  localparam logic [6:0] ROUND_B2    = 7'd40;
  localparam logic [6:0] ROUND_B3    = 7'd60;

  // Byte position where the 64-bit length starts (bit 448)
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [7:0] PAD_MARKER  = 8'h80;

endpackage

`default_nettype wire

// ----- design/sha1sh_ifs.sv -----
// Valid/ready channel interfaces for message bytes and digests
`timescale 1ns / 1ps
`default_nettype none

interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_item;

  modport source (output valid, data_byte, has_byte, last_item, input ready);
  modport sink   (input valid, data_byte, has_byte, last_item, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_high;
  logic [63:0] digest_mid;
  logic [31:0] digest_low;

  modport source (output valid, digest_high, digest_mid, digest_low, input ready);
  modport sink   (input valid, digest_high, digest_mid, digest_low, output ready);
endinterface

`default_nettype wire

// ----- design/sha1sh_sched.sv -----
// Block buffer and message schedule: byte shift-in, one schedule word per round
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_sched (
  input  wire logic                     clk,
  input  wire sha1sh_pkg::sched_ctrl_t  ctrl,
  output logic [31:0]                   w_cur
);
  import sha1sh_pkg::*;

  // Oldest word sits in the top 32 bits
  logic [511:0] blk;
  logic [31:0]  w_mix;
  logic [31:0]  w_new;

  assign w_cur = blk[511:480];

  // W[i+16] = rotl1(W[i+13] ^ W[i+8] ^ W[i+2] ^ W[i])
  assign w_mix = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_ff @(posedge clk) begin
    if (ctrl.load_byte) begin
      blk <= {blk[503:0], ctrl.byte_val};
    end else if (ctrl.shift_word) begin
      blk <= {blk[479:0], w_new};
    end
  end

endmodule

`default_nettype wire

// ----- design/sha1sh_round.sv -----
// One SHA-1 compression round, reused for all 80 rounds
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_round (
  input  wire sha1sh_pkg::work_t  work_in,
  input  wire logic [31:0]        w_cur,
  input  wire logic [6:0]         rnd,
  output sha1sh_pkg::work_t       work_out
);
  import sha1sh_pkg::*;

  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  // Round function and constant by round group
  always_comb begin
    if (rnd < ROUND_B1) begin
      f_val = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
      k_val = K_TAB[0];
    end else if (rnd < ROUND_B2) begin
      f_val = work_in.b ^ work_in.c ^ work_in.d;
      k_val = K_TAB[1];
    end else if (rnd < ROUND_B3) begin
      f_val = (work_in.b & work_in.c) | (work_in.b & work_in.d) | (work_in.c & work_in.d);
      k_val = K_TAB[2];
    end else begin
      f_val = work_in.b ^ work_in.c ^ work_in.d;
      k_val = K_TAB[3];
    end
  end

  assign t_val = {work_in.a[26:0], work_in.a[31:27]} + f_val + work_in.e + k_val + w_cur;

  // Rotate the working words
  assign work_out.a = t_val;
  assign work_out.b = work_in.a;
  assign work_out.c = {work_in.b[1:0], work_in.b[31:2]};
  assign work_out.d = work_in.c;
  assign work_out.e = work_in.d;

endmodule

`default_nettype wire

// ----- design/sha1_stream_hash_unit.sv -----
// SHA-1 stream hash unit: top level with sequencer and chaining state
//
// Usage:
//   in_ch  : one word per handshake: data_byte (valid when has_byte) and
//            last_item, which ends the message. ready is high only while the
//            unit waits for a word.
//   out_ch : one 160-bit digest (H0..H4) per message, held in an output
//            register until taken.
// Sequence:
//   A word that does not complete a 64-byte block leaves the unit idle and
//   ready. Completing a block runs 80 rounds on the single round unit, then
//   folds the result into the chaining words; no word is taken meanwhile.
//   An end mark pads one byte per cycle while no block is compressed
//   (marker, zeros, a step to switch to the length, eight length bytes),
//   compresses once or twice, and then loads the digest.
// Reset (rst, synchronous): chaining words to the SHA-1 initial values,
//   fill position and bit count to zero, output empty.
// Stall: while a digest waits on out_ch, new words are still taken; a second
//   end mark holds the unit in its digest step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module sha1_stream_hash_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  sha1sh_in_if.sink    in_ch,
  sha1sh_out_if.source out_ch
);
  import sha1sh_pkg::*;
  `include "sha1_stream_hash_unit_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_FOLD   = 5'b01000,
    ST_DIGEST = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    PH_MARK = 4'b0001,
    PH_ZERO = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_DONE = 4'b1000
  } pad_phase_t;

  state_t      state;
  pad_phase_t  pad_phase;
  logic        pad_active;
  logic [2:0]  len_idx;
  logic [6:0]  rnd;
  logic [5:0]  fill;
  logic [63:0] bit_count;
  work_t       chain;
  work_t       work;
  work_t       round_out;
  logic        out_valid;
  logic [63:0] out_high;
  logic [63:0] out_mid;
  logic [31:0] out_low;

  logic        in_take;
  logic        out_free;
  logic        byte_wr;
  logic [7:0]  byte_val;
  logic        block_full;
  logic [31:0] w_cur;
  sched_ctrl_t sched_ctrl;

  assign in_ch.ready        = (state == ST_IDLE);
  assign in_take            = in_ch.valid && (state == ST_IDLE);
  assign out_free           = !out_valid || out_ch.ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.digest_high = out_high;
  assign out_ch.digest_mid  = out_mid;
  assign out_ch.digest_low  = out_low;

  // Byte source: message bytes when idle, padding bytes when padding
  always_comb begin
    byte_wr  = 1'b0;
    byte_val = in_ch.data_byte;
    if (state == ST_IDLE) begin
      byte_wr = in_take && in_ch.has_byte;
    end else if (state == ST_PAD) begin
      unique case (pad_phase)
        PH_MARK: begin
          byte_wr  = 1'b1;
          byte_val = PAD_MARKER;
        end
        PH_ZERO: begin
          byte_wr  = (fill != LEN_OFFSET);
          byte_val = 8'h00;
        end
        PH_LEN: begin
          byte_wr  = 1'b1;
          byte_val = bit_count[{~len_idx, 3'b000} +: 8];
        end
        default: begin
          byte_wr  = 1'b0;
          byte_val = 8'h00;
        end
      endcase
    end
  end

  assign block_full = byte_wr && (fill == FILL_LAST);

  assign sched_ctrl.load_byte  = byte_wr;
  assign sched_ctrl.shift_word = (state == ST_ROUND);
  assign sched_ctrl.byte_val   = byte_val;

  sha1sh_sched u_sched (
    .clk   (clk),
    .ctrl  (sched_ctrl),
    .w_cur (w_cur)
  );

  sha1sh_round u_round (
    .work_in  (work),
    .w_cur    (w_cur),
    .rnd      (rnd),
    .work_out (round_out)
  );

  // Sequencer and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pad_phase  <= PH_MARK;
      pad_active <= 1'b0;
      len_idx    <= 3'd0;
      rnd        <= 7'd0;
      fill       <= 6'd0;
      bit_count  <= 64'd0;
      chain      <= H_INIT;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (byte_wr) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (in_ch.has_byte) begin
              bit_count <= bit_count + 64'd8;
            end
            if (in_ch.last_item) begin
              pad_active <= 1'b1;
              pad_phase  <= PH_MARK;
            end
            if (block_full) begin
              state <= ST_ROUND;
              rnd   <= 7'd0;
            end else if (in_ch.last_item) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          unique case (pad_phase)
            PH_MARK: pad_phase <= PH_ZERO;
            PH_ZERO: begin
              if (fill == LEN_OFFSET) begin
                pad_phase <= PH_LEN;
                len_idx   <= 3'd0;
              end
            end
            PH_LEN: begin
              len_idx <= len_idx + 3'd1;
              if (len_idx == 3'd7) begin
                pad_phase <= PH_DONE;
              end
            end
            default: pad_phase <= PH_DONE;
          endcase
          if (block_full) begin
            state <= ST_ROUND;
            rnd   <= 7'd0;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == ROUND_LAST) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain.a <= chain.a + work.a;
          chain.b <= chain.b + work.b;
          chain.c <= chain.c + work.c;
          chain.d <= chain.d + work.d;
          chain.e <= chain.e + work.e;
          if (!pad_active) begin
            state <= ST_IDLE;
          end else if (pad_phase == PH_DONE) begin
            state <= ST_DIGEST;
          end else begin
            state <= ST_PAD;
          end
        end
        ST_DIGEST: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            chain      <= H_INIT;
            fill       <= 6'd0;
            bit_count  <= 64'd0;
            pad_active <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working words and digest register
  always_ff @(posedge clk) begin
    if (block_full) begin
      work <= chain;
    end else if (state == ST_ROUND) begin
      work <= round_out;
    end
    if (state == ST_DIGEST && out_free) begin
      out_high <= {chain.a, chain.b};
      out_mid  <= {chain.c, chain.d};
      out_low  <= chain.e;
    end
  end

  // Checks on the sequencer
  `SHA1SH_ASSERT_IMP(a_rnd_range, clk, rst, state == ST_ROUND, rnd < ROUND_COUNT)
  `SHA1SH_ASSERT_NXT(a_last_round, clk, rst,
                     state == ST_ROUND && rnd == ROUND_LAST, state == ST_FOLD)
  `SHA1SH_ASSERT_IMP(a_digest_aligned, clk, rst,
                     state == ST_DIGEST, fill == 6'd0 && pad_phase == PH_DONE)
  `SHA1SH_ASSERT_NXT(a_reinit, clk, rst, state == ST_DIGEST && out_free,
                     out_valid && chain == H_INIT && bit_count == 64'd0)

endmodule

`default_nettype wire
